// ----- rtl/tcl_pkg.sv -----
// Package for the tile cache LRU lookup block.
// Holds sizes, field widths, command codes and the controller/datapath command and status types.
// No dependencies.
package tcl_pkg;

    localparam int CACHE_ENTRIES = 64;
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int ZOOM_W = 5;
    localparam int COORD_W = 30;
    localparam int STAMP_W = 32;
    localparam int SLOT_W = 6;
    localparam int TAG_W = ZOOM_W + 2 * COORD_W;

    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    typedef struct packed {
        logic frame_inc;
        logic load_req;
        logic rd;
        logic wr;
    } ctl_t;

    typedef struct packed {
        logic scan_last;
    } sts_t;

endpackage

// ----- rtl/tcl_req_if.sv -----
// Request channel of the tile cache lookup: valid/ready handshake and request fields.
// Depends on tcl_pkg for field widths.
interface tcl_req_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [tcl_pkg::ZOOM_W-1:0]  tile_z;
    logic [tcl_pkg::COORD_W-1:0] tile_x;
    logic [tcl_pkg::COORD_W-1:0] tile_y;

    modport source (output valid, cmd, tile_z, tile_x, tile_y, input ready);
    modport sink (input valid, cmd, tile_z, tile_x, tile_y, output ready);
endinterface

// ----- rtl/tcl_rsp_if.sv -----
// Result channel of the tile cache lookup: valid/ready handshake and result fields.
// Depends on tcl_pkg for field widths.
interface tcl_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [tcl_pkg::SLOT_W-1:0]  slot;
    logic                        evicted;
    logic [tcl_pkg::ZOOM_W-1:0]  evicted_zoom;
    logic [tcl_pkg::COORD_W-1:0] evicted_x;
    logic [tcl_pkg::COORD_W-1:0] evicted_y;

    modport source (output valid, hit, slot, evicted, evicted_zoom, evicted_x, evicted_y,
                    input ready);
    modport sink (input valid, hit, slot, evicted, evicted_zoom, evicted_x, evicted_y,
                  output ready);
endinterface

// ----- rtl/tcl_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module tcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                           wdata,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- rtl/tcl_ctrl.sv -----
// Controller state machine of the tile cache lookup: sequences accept, scan, drain, write and result.
// Depends on tcl_pkg for the command codes and the command and status types.
module tcl_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_cmd,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  tcl_pkg::sts_t sts,
    output tcl_pkg::ctl_t ctl
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cmd == tcl_pkg::CMD_REQUEST)
                    begin
                        ctl.load_req = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        ctl.frame_inc = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                ctl.rd = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                ctl.wr = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

endmodule

// ----- rtl/tcl_dp.sv -----
// Datapath of the tile cache lookup: tag store RAM, valid bits, use counter and scan trackers.
// Depends on tcl_pkg and tcl_ram.
module tcl_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcl_pkg::ctl_t                 ctl,
    output tcl_pkg::sts_t                 sts,
    input  logic [tcl_pkg::ZOOM_W-1:0]    in_zoom,
    input  logic [tcl_pkg::COORD_W-1:0]   in_x,
    input  logic [tcl_pkg::COORD_W-1:0]   in_y,
    output logic                          hit,
    output logic [tcl_pkg::SLOT_W-1:0]    slot,
    output logic                          evicted,
    output logic [tcl_pkg::ZOOM_W-1:0]    evicted_zoom,
    output logic [tcl_pkg::COORD_W-1:0]   evicted_x,
    output logic [tcl_pkg::COORD_W-1:0]   evicted_y
);

    localparam int N = tcl_pkg::CACHE_ENTRIES;
    localparam int IW = tcl_pkg::IDX_W;
    localparam int TW = tcl_pkg::TAG_W;
    localparam int SW = tcl_pkg::STAMP_W;
    localparam int OW = tcl_pkg::SLOT_W;

    logic [TW-1:0]  req_tag_reg;
    logic [SW-1:0]  counter_reg;
    logic [N-1:0]   valid_reg;
    logic [IW-1:0]  addr_reg;
    logic [IW-1:0]  cmp_idx_reg;
    logic           cmp_en_reg;
    logic           hit_reg;
    logic [IW-1:0]  hit_idx_reg;
    logic           inv_found_reg;
    logic [IW-1:0]  inv_idx_reg;
    logic           best_found_reg;
    logic [IW-1:0]  best_idx_reg;
    logic [SW-1:0]  best_stamp_reg;
    logic [TW-1:0]  best_tag_reg;

    logic [IW-1:0]     ram_addr;
    logic [TW+SW-1:0]  ram_rdata;
    logic [TW-1:0]     rd_tag;
    logic [SW-1:0]     rd_stamp;
    logic              rd_valid;
    logic [IW-1:0]     victim_idx;
    logic [IW-1:0]     wr_idx;
    logic [OW+IW-1:0]  slot_ext;

    assign rd_tag = ram_rdata[TW+SW-1:SW];
    assign rd_stamp = ram_rdata[SW-1:0];
    assign rd_valid = valid_reg[cmp_idx_reg];
    assign victim_idx = inv_found_reg ? inv_idx_reg : best_idx_reg;
    assign wr_idx = hit_reg ? hit_idx_reg : victim_idx;
    assign ram_addr = ctl.wr ? wr_idx : addr_reg;
    assign sts.scan_last = (addr_reg == IW'(N - 1));
    assign slot_ext = {{OW{1'b0}}, wr_idx};

    tcl_ram #(
        .WIDTH(TW + SW),
        .DEPTH(N)
    ) u_store (
        .clk  (clk),
        .we   (ctl.wr),
        .addr (ram_addr),
        .wdata({req_tag_reg, counter_reg}),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.load_req)
        begin
            req_tag_reg <= {in_zoom, in_x, in_y};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            valid_reg <= '0;
            addr_reg <= '0;
            cmp_idx_reg <= '0;
            cmp_en_reg <= 1'b0;
            hit_reg <= 1'b0;
            inv_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            cmp_en_reg <= ctl.rd;
            if (ctl.frame_inc)
            begin
                counter_reg <= counter_reg + 1'b1;
            end
            if (ctl.load_req)
            begin
                addr_reg <= '0;
                hit_reg <= 1'b0;
                inv_found_reg <= 1'b0;
                best_found_reg <= 1'b0;
            end
            if (ctl.rd)
            begin
                cmp_idx_reg <= addr_reg;
                addr_reg <= sts.scan_last ? '0 : addr_reg + 1'b1;
            end
            if (cmp_en_reg)
            begin
                if (rd_valid && (rd_tag == req_tag_reg) && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (!rd_valid && !inv_found_reg)
                begin
                    inv_found_reg <= 1'b1;
                end
                if (rd_valid && (!best_found_reg || (rd_stamp < best_stamp_reg)))
                begin
                    best_found_reg <= 1'b1;
                end
            end
            if (ctl.wr)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_en_reg)
        begin
            if (rd_valid && (rd_tag == req_tag_reg) && !hit_reg)
            begin
                hit_idx_reg <= cmp_idx_reg;
            end
            if (!rd_valid && !inv_found_reg)
            begin
                inv_idx_reg <= cmp_idx_reg;
            end
            if (rd_valid && (!best_found_reg || (rd_stamp < best_stamp_reg)))
            begin
                best_idx_reg <= cmp_idx_reg;
                best_stamp_reg <= rd_stamp;
                best_tag_reg <= rd_tag;
            end
        end
        if (ctl.wr)
        begin
            hit <= hit_reg;
            slot <= slot_ext[OW-1:0];
            evicted <= !hit_reg && !inv_found_reg;
            if (!hit_reg && !inv_found_reg)
            begin
                evicted_zoom <= best_tag_reg[TW-1:TW-tcl_pkg::ZOOM_W];
                evicted_x <= best_tag_reg[2*tcl_pkg::COORD_W-1:tcl_pkg::COORD_W];
                evicted_y <= best_tag_reg[tcl_pkg::COORD_W-1:0];
            end
            else
            begin
                evicted_zoom <= '0;
                evicted_x <= '0;
                evicted_y <= '0;
            end
        end
    end

endmodule

// ----- rtl/tile_cache_lru_lookup_top.sv -----
// Top level of the tile cache LRU lookup block.
// Depends on tcl_pkg, tcl_req_if, tcl_rsp_if, tcl_ctrl, tcl_dp and tcl_ram.
//
// Usage:
// The req channel takes one item at a time with valid/ready. An item with cmd
// low is a frame command: it advances the 32-bit use counter in the cycle it is
// accepted and produces no result. An item with cmd high is a tile request: the
// block reads its tag store once per entry through the single RAM port, one entry
// per cycle, then writes back the touched entry and presents one item on rsp.
// A request runs through the scan over the RAM port, the drain, the write and
// the result in turn; a new item is taken only once the result has been taken
// and the block is back in idle.
// Frame commands are taken one per cycle while the block is idle.
// If the receiver holds rsp ready low, the result stays on rsp and req ready
// stays low until the item is taken. Reset empties the store through its valid
// bits and clears the use counter at once; no clearing pass is needed.
module tile_cache_lru_lookup_top (
    input  logic      clk,
    input  logic      rst_n,
    tcl_req_if.sink   req,
    tcl_rsp_if.source rsp
);

    tcl_pkg::ctl_t ctl;
    tcl_pkg::sts_t sts;

    tcl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_cmd   (req.cmd),
        .in_ready (req.ready),
        .out_valid(rsp.valid),
        .out_ready(rsp.ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    tcl_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .in_zoom     (req.tile_z),
        .in_x        (req.tile_x),
        .in_y        (req.tile_y),
        .hit         (rsp.hit),
        .slot        (rsp.slot),
        .evicted     (rsp.evicted),
        .evicted_zoom(rsp.evicted_zoom),
        .evicted_x   (rsp.evicted_x),
        .evicted_y   (rsp.evicted_y)
    );

endmodule
